@@ design/assert_macros.svh @@
// assertion macros shared by the orbit representative design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, sampled on clk, off during reset
`define ORC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication, sampled on clk, off during reset
`define ORC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`endif

@@ design/orc_pkg.sv @@
// shared constants and types of the orbit representative block
`timescale 1ns / 1ps
package orc_pkg;
    localparam int DATA_W     = 64;
    localparam int EIG_W      = 18;
    localparam int NORM_W     = 17;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_MASKS  = 64;
    localparam int MAX_STAGES = 16;
    localparam int GRP_W      = 6;
    localparam int STG_W      = 4;
    localparam int SHIFT_W    = 6;
    localparam int ADDR_W     = GRP_W + STG_W;
    localparam int SUM_W      = 25;
    localparam int NUM_W      = SUM_W - 1 + FRAC_BITS;
    localparam int DIVR_W     = 8;
    localparam int ROOT_W     = NUM_W / 2;
    localparam int CNT_W      = 6;
    localparam int IN_W       = 120;
    localparam int OUT_W      = 120;

    // request kinds
    localparam logic [1:0] REQ_MASK  = 2'd0;
    localparam logic [1:0] REQ_SHIFT = 2'd1;
    localparam logic [1:0] REQ_EIG   = 2'd2;
    localparam logic [1:0] REQ_QUERY = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_FLIP  = 2'd0;
    localparam logic [1:0] CFG_INV   = 2'd1;
    localparam logic [1:0] CFG_MASKS = 2'd2;
    localparam logic [1:0] CFG_STGS  = 2'd3;

    // inversion modes
    localparam logic [1:0] INV_NONE = 2'd0;
    localparam logic [1:0] INV_EVEN = 2'd1;
    localparam logic [1:0] INV_ODD  = 2'd2;

    typedef struct packed {
        logic             start_query;
        logic             wr_mask;
        logic             wr_shift;
        logic             wr_eig;
        logic             swap_en;
        logic             consider;
        logic             norm_start;
        logic             out_load;
        logic [GRP_W-1:0] group;
        logic [STG_W-1:0] stage;
        logic [STG_W-1:0] rd_stage;
    } orc_cmd_t;

    typedef struct packed {
        logic [GRP_W-1:0] n_last;
        logic [STG_W-1:0] st_last;
        logic             out_valid;
        logic             norm_done;
    } orc_sts_t;
endpackage

@@ design/orc_nsq.sv @@
// iterative norm unit: restoring division then digit-by-digit square root
`timescale 1ns / 1ps
module orc_nsq
    import orc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [SUM_W-1:0]  sum,
    input  logic [DIVR_W-1:0]        divisor,
    output logic                     done,
    output logic [NORM_W-1:0]        norm
);
    localparam logic [1:0] NSQ_IDLE = 2'd0;
    localparam logic [1:0] NSQ_DIV  = 2'd1;
    localparam logic [1:0] NSQ_SQRT = 2'd2;
    localparam int SQ_W = ROOT_W + 4;
    localparam logic [ROOT_W-1:0] ONE = ROOT_W'(1 << FRAC_BITS);

    logic [1:0]        phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [DIVR_W-1:0] divr_reg, divr_next;
    logic [DIVR_W-1:0] rem_reg, rem_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [NORM_W-1:0] norm_reg, norm_next;
    logic [DIVR_W:0]   rsh;
    logic [SQ_W-1:0]   srs, trial;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= NSQ_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        divr_reg <= divr_next;
        rem_reg  <= rem_next;
        sq_reg   <= sq_next;
        root_reg <= root_next;
        norm_reg <= norm_next;
    end

    // one quotient bit or one root bit per cycle
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        num_next   = num_reg;
        divr_next  = divr_reg;
        rem_next   = rem_reg;
        sq_next    = sq_reg;
        root_next  = root_reg;
        norm_next  = norm_reg;
        rsh        = {rem_reg, num_reg[NUM_W-1]};
        srs        = {sq_reg[SQ_W-3:0], num_reg[NUM_W-1:NUM_W-2]};
        trial      = {2'b00, root_reg, 2'b01};
        case (phase_reg)
            NSQ_IDLE:
            begin
                if (start)
                begin
                    if (sum > 0)
                        num_next = {sum[SUM_W-2:0], {FRAC_BITS{1'b0}}};
                    else
                        num_next = '0;
                    divr_next  = divisor;
                    rem_next   = '0;
                    cnt_next   = '0;
                    phase_next = NSQ_DIV;
                end
            end
            NSQ_DIV:
            begin
                if (rsh >= {1'b0, divr_reg})
                begin
                    rem_next = DIVR_W'(rsh - {1'b0, divr_reg});
                    num_next = {num_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rsh[DIVR_W-1:0];
                    num_next = {num_reg[NUM_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    cnt_next   = '0;
                    sq_next    = '0;
                    root_next  = '0;
                    phase_next = NSQ_SQRT;
                end
            end
            NSQ_SQRT:
            begin
                num_next = {num_reg[NUM_W-3:0], 2'b00};
                if (srs >= trial)
                begin
                    sq_next   = srs - trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sq_next   = srs;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    phase_next = NSQ_IDLE;
                    done_next  = 1'b1;
                    if (root_next > ONE)
                        norm_next = NORM_W'(ONE);
                    else
                        norm_next = root_next[NORM_W-1:0];
                end
            end
            default:
            begin
                phase_next = NSQ_IDLE;
            end
        endcase
    end

    assign done = done_reg;
    assign norm = norm_reg;
endmodule

@@ design/orc_dp.sv @@
// datapath: tables, delta-swap stage, running minimum, norm sum, output register
`timescale 1ns / 1ps
module orc_dp
    import orc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  orc_cmd_t                cmd,
    output orc_sts_t                sts,
    input  logic                    norm_done,
    input  logic [NORM_W-1:0]       norm,
    output logic signed [SUM_W-1:0] sum,
    output logic [DIVR_W-1:0]       divisor,
    input  logic [IN_W-1:0]         in_data,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [DATA_W-1:0]       cfg_data,
    input  logic                    m_tready,
    output logic                    m_tvalid,
    output logic [OUT_W-1:0]        m_tdata
);
    localparam logic signed [EIG_W-1:0] CHAR_ONE = EIG_W'(1 << FRAC_BITS);
    localparam logic signed [EIG_W-1:0] EIG_MAX  = {1'b0, {(EIG_W-1){1'b1}}};
    localparam logic signed [EIG_W-1:0] EIG_MIN  = {1'b1, {(EIG_W-1){1'b0}}};

    function automatic logic [DATA_W-1:0] delta_swap(
        input logic [DATA_W-1:0]  y,
        input logic [DATA_W-1:0]  m,
        input logic [SHIFT_W-1:0] d
    );
        logic [DATA_W-1:0] t;
        t = ((y >> d) ^ y) & m;
        return y ^ t ^ (t << d);
    endfunction

    function automatic logic signed [EIG_W-1:0] neg_sat(input logic signed [EIG_W-1:0] v);
        if (v == EIG_MIN)
            return EIG_MAX;
        else
            return -v;
    endfunction

    // input fields
    logic [GRP_W-1:0]        in_group;
    logic [STG_W-1:0]        in_stage;
    logic [DATA_W-1:0]       in_word;
    logic [SHIFT_W-1:0]      in_shift;
    logic [2*EIG_W-1:0]      in_eig;
    assign in_group = in_data[5:0];
    assign in_stage = in_data[9:6];
    assign in_word  = in_data[73:10];
    assign in_shift = in_data[79:74];
    assign in_eig   = in_data[115:80];

    // configuration registers
    logic [DATA_W-1:0] flip_reg;
    logic [1:0]        inv_reg;
    logic [6:0]        masks_reg;
    logic [4:0]        stgs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_reg  <= '0;
            inv_reg   <= INV_NONE;
            masks_reg <= 7'd1;
            stgs_reg  <= 5'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FLIP:  flip_reg  <= cfg_data;
                CFG_INV:   inv_reg   <= cfg_data[1:0];
                CFG_MASKS: masks_reg <= cfg_data[6:0];
                CFG_STGS:  stgs_reg  <= cfg_data[4:0];
                default:   flip_reg  <= flip_reg;
            endcase
        end
    end

    // clamped counts and effective mode
    logic [GRP_W-1:0] n_last;
    logic [STG_W-1:0] st_last;
    logic [1:0]       mode;
    always_comb
    begin
        if (masks_reg == 7'd0)
            n_last = '0;
        else if (masks_reg > 7'(NUM_MASKS))
            n_last = GRP_W'(NUM_MASKS - 1);
        else
            n_last = GRP_W'(masks_reg - 7'd1);
        if (stgs_reg == 5'd0)
            st_last = '0;
        else if (stgs_reg > 5'(MAX_STAGES))
            st_last = STG_W'(MAX_STAGES - 1);
        else
            st_last = STG_W'(stgs_reg - 5'd1);
        mode = (inv_reg == INV_EVEN || inv_reg == INV_ODD) ? inv_reg : INV_NONE;
    end

    logic [6:0] n_cnt;
    assign n_cnt   = {1'b0, n_last} + 7'd1;
    assign divisor = (mode == INV_NONE) ? {1'b0, n_cnt} : {n_cnt, 1'b0};

    // mask memory, one word per symmetry and stage
    logic [DATA_W-1:0] mask_mem [NUM_MASKS*MAX_STAGES];
    logic [DATA_W-1:0] mask_q;
    always_ff @(posedge clk)
    begin
        if (cmd.wr_mask)
            mask_mem[{in_group, in_stage}] <= in_word;
        mask_q <= mask_mem[{cmd.group, cmd.rd_stage}];
    end

    // eigenvalue memory, real part in the low half
    logic [2*EIG_W-1:0] eig_mem [NUM_MASKS];
    logic [2*EIG_W-1:0] eig_q;
    always_ff @(posedge clk)
    begin
        if (cmd.wr_eig)
            eig_mem[in_group] <= in_eig;
        eig_q <= eig_mem[cmd.group];
    end

    // shift distances per stage
    logic [SHIFT_W-1:0] shift_tab [MAX_STAGES];
    always_ff @(posedge clk)
    begin
        if (cmd.wr_shift)
            shift_tab[in_stage] <= in_shift;
    end

    // query state
    logic [DATA_W-1:0]       x_reg, y_reg, best_reg;
    logic signed [EIG_W-1:0] cre_reg, cim_reg;
    logic signed [SUM_W-1:0] sum_reg;

    logic signed [EIG_W-1:0] e_re, e_im, f_re, f_im;
    logic [DATA_W-1:0]       y_inv, best_a, best_b;
    logic signed [EIG_W-1:0] cre_a, cim_a, cre_b, cim_b;
    logic signed [SUM_W-1:0] sum_a, sum_b;

    // consider the image and, with inversion, its flipped twin
    always_comb
    begin
        e_re  = eig_q[EIG_W-1:0];
        e_im  = eig_q[2*EIG_W-1:EIG_W];
        f_re  = (mode == INV_ODD) ? neg_sat(e_re) : e_re;
        f_im  = (mode == INV_ODD) ? neg_sat(e_im) : e_im;
        y_inv = y_reg ^ flip_reg;
        best_a = best_reg;
        cre_a  = cre_reg;
        cim_a  = cim_reg;
        sum_a  = sum_reg;
        if (y_reg < best_reg)
        begin
            best_a = y_reg;
            cre_a  = e_re;
            cim_a  = e_im;
        end
        if (y_reg == x_reg)
            sum_a = sum_reg + SUM_W'(e_re);
        best_b = best_a;
        cre_b  = cre_a;
        cim_b  = cim_a;
        sum_b  = sum_a;
        if (mode != INV_NONE)
        begin
            if (y_inv < best_a)
            begin
                best_b = y_inv;
                cre_b  = f_re;
                cim_b  = f_im;
            end
            if (y_inv == x_reg)
                sum_b = sum_a + SUM_W'(f_re);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_query)
        begin
            x_reg    <= in_word;
            y_reg    <= in_word;
            best_reg <= in_word;
            cre_reg  <= CHAR_ONE;
            cim_reg  <= '0;
            sum_reg  <= '0;
        end
        else if (cmd.swap_en)
        begin
            y_reg <= delta_swap(y_reg, mask_q, shift_tab[cmd.stage]);
        end
        else if (cmd.consider)
        begin
            best_reg <= best_b;
            cre_reg  <= cre_b;
            cim_reg  <= cim_b;
            sum_reg  <= sum_b;
            y_reg    <= x_reg;
        end
    end

    assign sum = sum_reg;

    // output register
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_data_reg <= {3'b000, norm, cim_reg, cre_reg, best_reg};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        sts.n_last    = n_last;
        sts.st_last   = st_last;
        sts.out_valid = out_valid_reg;
        sts.norm_done = norm_done;
    end
endmodule

@@ design/orc_ctrl.sv @@
// controller: sequences table writes, symmetry walk, norm unit and output load
`timescale 1ns / 1ps
`include "assert_macros.svh"
module orc_ctrl
    import orc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] req_type,
    input  logic       m_tready,
    input  orc_sts_t   sts,
    output orc_cmd_t   cmd
);
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PRIME  = 3'd1;
    localparam logic [2:0] ST_SWAP   = 3'd2;
    localparam logic [2:0] ST_CONS   = 3'd3;
    localparam logic [2:0] ST_NORM   = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;
    localparam logic [2:0] ST_NSTART = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [GRP_W-1:0] grp_reg, grp_next;
    logic [STG_W-1:0] stg_reg, stg_next;
    logic             accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            grp_reg   <= '0;
            stg_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            grp_reg   <= grp_next;
            stg_reg   <= stg_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        grp_next   = grp_reg;
        stg_next   = stg_reg;
        cmd        = '0;
        cmd.group    = grp_reg;
        cmd.stage    = stg_reg;
        cmd.rd_stage = stg_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.wr_mask  = accept && (req_type == REQ_MASK);
                cmd.wr_shift = accept && (req_type == REQ_SHIFT);
                cmd.wr_eig   = accept && (req_type == REQ_EIG);
                if (accept && req_type == REQ_QUERY)
                begin
                    cmd.start_query = 1'b1;
                    grp_next        = '0;
                    state_next      = ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                cmd.rd_stage = '0;
                stg_next     = '0;
                state_next   = ST_SWAP;
            end
            ST_SWAP:
            begin
                cmd.swap_en  = 1'b1;
                cmd.rd_stage = stg_reg + 1'b1;
                if (stg_reg == sts.st_last)
                    state_next = ST_CONS;
                else
                    stg_next = stg_reg + 1'b1;
            end
            ST_CONS:
            begin
                cmd.consider = 1'b1;
                if (grp_reg == sts.n_last)
                    state_next = ST_NSTART;
                else
                begin
                    grp_next   = grp_reg + 1'b1;
                    state_next = ST_PRIME;
                end
            end
            // launch the norm unit once the last sum is registered
            ST_NSTART:
            begin
                cmd.norm_start = 1'b1;
                state_next     = ST_NORM;
            end
            ST_NORM:
            begin
                if (sts.norm_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!sts.out_valid || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ORC_ASSERT_NEXT(a_swap_to_cons, state_reg == ST_SWAP && stg_reg == sts.st_last, state_reg == ST_CONS)
    `ORC_ASSERT_NEXT(a_last_to_nstart, state_reg == ST_CONS && grp_reg == sts.n_last, state_reg == ST_NSTART)
    `ORC_ASSERT_SAME(a_out_free, cmd.out_load, !sts.out_valid || m_tready)
endmodule

@@ design/orbit_representative_character_norm.sv @@
// top level: orbit representative, character and norm under delta-swap symmetries
// a query walks its n symmetries, each through the swap stages, then runs the norm unit
// throughput: one query at a time; the mask memory port gives one stage per cycle
// and the norm unit runs a restoring division, then a digit-by-digit square root
// a finished result may wait in the output register while new items are taken
// reset is asynchronous active low; it clears control and configuration, not the tables
`timescale 1ns / 1ps
module orbit_representative_character_norm
    import orc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // group_index, stage_index, data_word, shift_amount, eig_re, eig_im, zero pad
    input  logic [IN_W-1:0]   s_tdata,
    // req_type
    input  logic [1:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // representative, character_re, character_im, norm, zero pad
    output logic [OUT_W-1:0]  m_tdata,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [DATA_W-1:0] cfg_data
);
    orc_cmd_t                cmd;
    orc_sts_t                sts;
    logic                    norm_done;
    logic [NORM_W-1:0]       norm;
    logic signed [SUM_W-1:0] sum;
    logic [DIVR_W-1:0]       divisor;

    orc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    orc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .norm_done (norm_done),
        .norm      (norm),
        .sum       (sum),
        .divisor   (divisor),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

    orc_nsq u_nsq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.norm_start),
        .sum     (sum),
        .divisor (divisor),
        .done    (norm_done),
        .norm    (norm)
    );
endmodule

@@ tb/tb_orbit_representative_character_norm.sv @@
// testbench of the orbit representative block: random table loads and queries against a predictor
`timescale 1ns / 1ps
module tb_orbit_representative_character_norm;
    import orc_pkg::*;

    typedef struct {
        logic [1:0]           kind;
        logic [GRP_W-1:0]     grp;
        logic [STG_W-1:0]     stg;
        logic [DATA_W-1:0]    word;
        logic [SHIFT_W-1:0]   shamt;
        logic signed [EIG_W-1:0] ere;
        logic signed [EIG_W-1:0] eim;
    } orc_item_t;

    typedef struct {
        logic [DATA_W-1:0] rep;
        logic [EIG_W-1:0]  cre;
        logic [EIG_W-1:0]  cim;
        logic [NORM_W-1:0] norm;
    } orc_res_t;

    localparam int WATCHDOG = 20000;
    localparam int HOLD_LEN = 2000;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic [1:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [DATA_W-1:0] cfg_data;

    // predictor copy of the tables and registers
    logic [DATA_W-1:0]       mask_mem [NUM_MASKS*MAX_STAGES];
    logic [SHIFT_W-1:0]      dist_mem [MAX_STAGES];
    logic signed [EIG_W-1:0] ere_mem [NUM_MASKS];
    logic signed [EIG_W-1:0] eim_mem [NUM_MASKS];
    logic [DATA_W-1:0]       flip_reg;
    logic [1:0]              inv_reg;
    logic [6:0]              nsym_reg;
    logic [4:0]              nstg_reg;

    orc_item_t pend_items [$];
    orc_res_t  orbit_results [$];
    orc_item_t cur_item;

    int  n_pushed, n_taken, n_queries, n_results, n_errors, n_phases;
    int  s_gap, r_gap, hold_cnt, quiet;
    bit  s_took, idle_on, hold_req;

    orbit_representative_character_norm i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [EIG_W-1:0] negate_sat(logic signed [EIG_W-1:0] v);
        int n;
        n = -int'(v);
        if (n > 131071)
            n = 131071;
        return n[EIG_W-1:0];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] c;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (c * c <= v)
                r = c;
        end
        return r;
    endfunction

    // representative, character and norm of one query
    function automatic orc_res_t orbit_of(logic [DATA_W-1:0] x);
        orc_res_t                r;
        int                      n, st;
        logic [1:0]              mode;
        logic [DATA_W-1:0]       y, yy, t;
        logic signed [EIG_W-1:0] ce, ci;
        longint                  sum;
        logic [63:0]             q, root;
        n = (nsym_reg < 1) ? 1 : (nsym_reg > NUM_MASKS) ? NUM_MASKS : nsym_reg;
        st = (nstg_reg < 1) ? 1 : (nstg_reg > MAX_STAGES) ? MAX_STAGES : nstg_reg;
        mode = (inv_reg == 2'd3) ? INV_NONE : inv_reg;
        r.rep = x;
        r.cre = 18'd65536;
        r.cim = '0;
        sum = 0;
        for (int g = 0; g < n; g++)
        begin
            y = x;
            for (int s = 0; s < st; s++)
            begin
                t = ((y >> dist_mem[s]) ^ y) & mask_mem[g*MAX_STAGES + s];
                y = y ^ t ^ (t << dist_mem[s]);
            end
            // plain image, then the spin-flipped one
            for (int k = 0; k < 2; k++)
            begin
                if (k == 1 && mode == INV_NONE)
                    break;
                yy = (k == 1) ? (y ^ flip_reg) : y;
                ce = (k == 1 && mode == INV_ODD) ? negate_sat(ere_mem[g]) : ere_mem[g];
                ci = (k == 1 && mode == INV_ODD) ? negate_sat(eim_mem[g]) : eim_mem[g];
                if (yy < r.rep)
                begin
                    r.rep = yy;
                    r.cre = ce;
                    r.cim = ci;
                end
                if (yy == x)
                    sum += longint'(ce);
            end
        end
        if (sum <= 0)
            r.norm = '0;
        else
        begin
            q = (64'(sum) << FRAC_BITS) / ((mode == INV_NONE) ? n : 2*n);
            root = int_sqrt(q);
            if (root > 65536)
                root = 65536;
            r.norm = root[NORM_W-1:0];
        end
        return r;
    endfunction

    // accept side: update tables or predict, and check results
    always @(posedge clk)
    begin
        orc_res_t e;
        orc_res_t a;
        s_took = s_tvalid && s_tready;
        if (s_took)
        begin
            n_taken++;
            quiet = 0;
            case (cur_item.kind)
                REQ_MASK:  mask_mem[cur_item.grp*MAX_STAGES + cur_item.stg] = cur_item.word;
                REQ_SHIFT: dist_mem[cur_item.stg] = cur_item.shamt;
                REQ_EIG:
                begin
                    ere_mem[cur_item.grp] = cur_item.ere;
                    eim_mem[cur_item.grp] = cur_item.eim;
                end
                default:
                begin
                    orbit_results.push_back(orbit_of(cur_item.word));
                    n_queries++;
                end
            endcase
        end
        if (m_tvalid && m_tready)
        begin
            quiet = 0;
            n_results++;
            a.rep = m_tdata[63:0];
            a.cre = m_tdata[81:64];
            a.cim = m_tdata[99:82];
            a.norm = m_tdata[116:100];
            if (orbit_results.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result rep=%h", a.rep);
            end
            else
            begin
                e = orbit_results.pop_front();
                if (a.rep !== e.rep || a.cre !== e.cre || a.cim !== e.cim
                    || a.norm !== e.norm)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch exp rep=%h re=%h im=%h norm=%h",
                                 e.rep, e.cre, e.cim, e.norm,
                                 " got rep=%h re=%h im=%h norm=%h",
                                 a.rep, a.cre, a.cim, a.norm);
                end
            end
        end
    end

    // watchdog on cycles without any accept or result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet++;
            if (quiet >= WATCHDOG)
            begin
                $display("FAIL orbit_representative_character_norm");
                $finish;
            end
        end
    end

    // sender: next item from the pending queue, with idle bursts
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || s_took))
        begin
            s_took = 1'b0;
            if (s_gap > 0)
            begin
                s_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pend_items.size() > 0)
            begin
                cur_item = pend_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= cur_item.kind;
                s_tdata <= {4'd0, cur_item.eim, cur_item.ere, cur_item.shamt, cur_item.word,
                            cur_item.stg, cur_item.grp};
                if (idle_on && $urandom_range(0, 7) == 0)
                    s_gap = $urandom_range(1, 11);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: idle bursts and one long hold-off
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cnt = HOLD_LEN;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_tready <= 1'b0;
        end
        else if (r_gap > 0)
        begin
            r_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0)
                r_gap = $urandom_range(1, 11);
        end
    end

    function automatic logic signed [EIG_W-1:0] pick_eig();
        case ($urandom_range(0, 5))
            0: return -18'sd131072;
            1: return 18'sd65536;
            2: return -18'sd65536;
            3: return 18'sd131071;
            default: return EIG_W'($urandom_range(0, 18'h3FFFF));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'(1) << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic push_item(logic [1:0] kind, int grp, int stg, logic [DATA_W-1:0] word,
                             int shamt, logic signed [EIG_W-1:0] ere,
                             logic signed [EIG_W-1:0] eim);
        orc_item_t it;
        it.kind = kind;
        it.grp = GRP_W'(grp);
        it.stg = STG_W'(stg);
        it.word = word;
        it.shamt = SHIFT_W'(shamt);
        it.ere = ere;
        it.eim = eim;
        pend_items.push_back(it);
        n_pushed++;
    endtask

    // random item: query with given odds, otherwise a table write
    task automatic push_random(int q_pct);
        logic [DATA_W-1:0] w;
        w = ($urandom_range(0, 1) == 0) ? '0 : pick_word();
        if ($urandom_range(0, 99) < q_pct)
            push_item(REQ_QUERY, $urandom_range(0, 63), $urandom_range(0, 15), pick_word(),
                      $urandom_range(0, 63), pick_eig(), pick_eig());
        else
            case ($urandom_range(0, 2))
                0: push_item(REQ_MASK, $urandom_range(0, 63), $urandom_range(0, 15), w,
                             $urandom_range(0, 63), pick_eig(), pick_eig());
                1: push_item(REQ_SHIFT, $urandom_range(0, 63), $urandom_range(0, 15),
                             pick_word(), ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 63),
                             pick_eig(), pick_eig());
                default: push_item(REQ_EIG, $urandom_range(0, 63), $urandom_range(0, 15),
                                   pick_word(), $urandom_range(0, 63), pick_eig(), pick_eig());
            endcase
    endtask

    task automatic drain();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (n_taken != n_pushed || orbit_results.size() > 0);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_FLIP:  flip_reg = val;
            CFG_INV:   inv_reg = val[1:0];
            CFG_MASKS: nsym_reg = val[6:0];
            default:   nstg_reg = val[4:0];
        endcase
    endtask

    task automatic run_phase(int nsym, int nstg, int inv, logic [DATA_W-1:0] flip,
                             int count, int q_pct);
        drain();
        write_reg(CFG_FLIP, flip);
        write_reg(CFG_INV, DATA_W'(inv));
        write_reg(CFG_MASKS, DATA_W'(nsym));
        write_reg(CFG_STGS, DATA_W'(nstg));
        n_phases++;
        for (int i = 0; i < count; i++)
            push_random(q_pct);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        flip_reg = '0;
        inv_reg = INV_NONE;
        nsym_reg = 7'd1;
        nstg_reg = 5'd1;
        idle_on = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill every table entry so no query reads an unwritten one
        for (int s = 0; s < MAX_STAGES; s++)
            push_item(REQ_SHIFT, 0, s, '0, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 63),
                      '0, '0);
        for (int g = 0; g < NUM_MASKS; g++)
        begin
            push_item(REQ_EIG, g, 0, '0, 0, pick_eig(), pick_eig());
            for (int s = 0; s < MAX_STAGES; s++)
                push_item(REQ_MASK, g, s, ($urandom_range(0, 1) == 0) ? '0 : pick_word(), 0,
                          '0, '0);
        end

        // directed: extreme states, eigenvalues and swap distances
        push_item(REQ_QUERY, 0, 0, '0, 0, '0, '0);
        push_item(REQ_QUERY, 0, 0, '1, 0, '0, '0);
        push_item(REQ_EIG, 0, 0, '0, 0, -18'sd131072, 18'sd131071);
        push_item(REQ_SHIFT, 0, 0, '0, 63, '0, '0);
        push_item(REQ_MASK, 0, 0, '1, 0, '0, '0);
        push_item(REQ_QUERY, 0, 0, 64'h8000_0000_0000_0001, 0, '0, '0);
        push_item(REQ_SHIFT, 0, 0, '0, 0, '0, '0);
        push_item(REQ_EIG, 0, 0, '0, 0, 18'sd131071, -18'sd65536);
        push_item(REQ_QUERY, 0, 0, 64'h1234_5678_9ABC_DEF0, 0, '0, '0);
        push_item(REQ_QUERY, 63, 15, 64'hFFFF_FFFF_0000_0000, 0, '0, '0);

        // random phases over several settings, extremes among them
        run_phase(2, 1, INV_ODD, '0, 40, 50);
        push_item(REQ_EIG, 1, 0, '0, 0, -18'sd131072, -18'sd131072);
        for (int i = 0; i < 10; i++)
            push_item(REQ_QUERY, 0, 0, pick_word(), 0, '0, '0);
        run_phase(64, 16, INV_EVEN, '1, 24, 60);
        run_phase(0, 0, INV_ODD, '0, 80, 40);
        run_phase(127, 31, 3, {$urandom, $urandom}, 16, 60);
        run_phase(4, 2, INV_ODD, '1, 100, 40);
        run_phase(8, 3, INV_EVEN, '0, 80, 40);
        // receiver holds off while the previous phase is still being drained
        hold_req = 1'b1;
        run_phase(16, 1, INV_ODD, {$urandom, $urandom}, 60, 40);
        run_phase(2, 4, INV_NONE, '0, 60, 40);
        run_phase(5, 5, INV_EVEN, '0, 60, 40);
        run_phase(1, 16, INV_ODD, '1, 60, 40);
        drain();
        idle_on = 1'b0;
        run_phase(3, 2, INV_ODD, '0, 80, 40);
        drain();

        $display("covered %0d items in %0d setting phases: %0d queries, %0d results checked",
                 n_taken, n_phases, n_queries, n_results);
        $display("mismatches: %0d", n_errors);
        if (n_errors == 0)
            $display("PASS orbit_representative_character_norm");
        else
            $display("FAIL orbit_representative_character_norm");
        $finish;
    end

endmodule
